>>> rtl/ptp_pkg.sv
// Shared widths, constants and pipeline payload types of the point-triangle projection.
package ptp_pkg;

  localparam int CRD_W  = 32;             // Q16.16 coordinate
  localparam int DIF_W  = CRD_W + 1;      // difference of two coordinates
  localparam int DOT_W  = 2 * DIF_W + 2;  // sum of three products
  localparam int GRM_W  = 2 * DOT_W;      // det, n1, n2
  localparam int WT_W   = 17;             // Q1.16 weight
  localparam int WS_W   = WT_W + 1;       // sum of two weights
  localparam int NUM_W  = WS_W + WT_W;    // edge correction numerator
  localparam int PRD_W  = WS_W + DIF_W;   // weight times edge
  localparam int ACC_W  = 53;             // projection accumulator
  localparam int LIM_W  = 32;
  localparam int NCRD   = 12;
  localparam int IN_DATA_W   = NCRD * CRD_W;
  localparam int OUT_DATA_W  = 152;
  localparam int OUT_USER_W  = 2;

  localparam logic [WT_W-1:0]        ONE_Q16  = 17'h10000;
  localparam logic signed [ACC_W-1:0] HALF_LSB = 53'sd32768;
  localparam logic [LIM_W-1:0]       LIMIT_RST = 32'd1;

  typedef struct packed {
    logic [2:0][CRD_W-1:0] pc;
    logic [2:0][DIF_W-1:0] e1;
    logic [2:0][DIF_W-1:0] e2;
  } geo_t;

  typedef struct packed {
    geo_t geo;
    logic deg;
    logic n1_neg;
    logic n1_big;
    logic n2_neg;
    logic n2_big;
  } gram_t;

  typedef struct packed {
    geo_t            geo;
    logic            deg;
    logic            interior;
    logic            corr;
    logic [WT_W-1:0] w1;
    logic [WT_W-1:0] w2;
    logic [WS_W-1:0] w12;
  } edge_t;

  typedef struct packed {
    logic                  valid_res;
    logic                  inside_res;
    logic [2:0][CRD_W-1:0] proj;
    logic [WT_W-1:0]       wa;
    logic [WT_W-1:0]       wb;
    logic [WT_W-1:0]       wc;
  } res_t;

endpackage

>>> rtl/point_triangle_projection.sv
// Point-triangle projection: one request per clock while in_tready is high. The latency
// from acceptance to the result appearing on the output port is set by the two
// 17-stage quotient pipelines (weight division over the Gram determinant, then the
// edge-correction division), the two 3-stage multiplier banks and the registers around
// them. A full pipeline moves on every cycle; a stalled output fills a one-entry skid
// register, after which the whole pipeline holds and in_tready drops until it drains.
module point_triangle_projection (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y, corner_b_z,
  // corner_c_x, corner_c_y, corner_c_z, query_x, query_y, query_z (32 bits each)
  input  logic [ptp_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // proj_x, proj_y, proj_z (32 bits each), weight_a, weight_b, weight_c (17 bits each)
  output logic [ptp_pkg::OUT_DATA_W-1:0]    out_tdata,
  // valid_res, inside_res
  output logic [ptp_pkg::OUT_USER_W-1:0]    out_tuser,
  input  logic                              cfg_we,
  input  logic [ptp_pkg::LIM_W-1:0]         cfg_wdata
);

  localparam int GRM_W = ptp_pkg::GRM_W;
  localparam int WT_W  = ptp_pkg::WT_W;

  logic [ptp_pkg::LIM_W-1:0] limit_r;
  logic                      en;
  logic                      g_vld, d_vld, p_vld;
  logic [GRM_W-1:0]          g_det, g_n1, g_n2;
  ptp_pkg::gram_t            g_side, d_side;
  logic [WT_W-1:0]           d_q1, d_q2;
  ptp_pkg::res_t             p_res, out_r, sk_r;
  logic                      out_vld_r, sk_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= ptp_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  assign en        = !sk_vld_r;
  assign in_tready = en;

  ptp_gram u_gram (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_tvalid && in_tready),
    .crd(in_tdata), .limit(limit_r),
    .out_vld(g_vld), .det(g_det), .n1(g_n1), .n2(g_n2), .side(g_side)
  );

  // numerator scaled by 2^16, pre-shifted right by one for the first quotient bit
  ptp_div #(.DW(GRM_W), .QW(WT_W), .SW($bits(ptp_pkg::gram_t))) u_wdiv (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(g_vld),
    .num1({1'b0, g_n1, {(WT_W-1){1'b0}}}),
    .num2({1'b0, g_n2, {(WT_W-1){1'b0}}}),
    .den(g_det), .side_in(g_side),
    .out_vld(d_vld), .quo1(d_q1), .quo2(d_q2), .side_out(d_side)
  );

  ptp_edge u_edge (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(d_vld),
    .q1(d_q1), .q2(d_q2), .side(d_side),
    .out_vld(p_vld), .res(p_res)
  );

  // output register with a one-entry skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      sk_vld_r  <= 1'b0;
    end else if (out_tready || !out_vld_r) begin
      if (sk_vld_r) begin
        out_vld_r <= 1'b1;
        sk_vld_r  <= 1'b0;
      end else begin
        out_vld_r <= p_vld;
      end
    end else if (en && p_vld) begin
      sk_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_vld_r) begin
      out_r <= sk_vld_r ? sk_r : p_res;
    end else if (en && p_vld) begin
      sk_r <= p_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'b0, out_r.wc, out_r.wb, out_r.wa, out_r.proj};
  assign out_tuser  = {out_r.inside_res, out_r.valid_res};

endmodule

>>> rtl/ptp_dly.sv
// Enabled delay line for payload that rides alongside a pipelined unit.
module ptp_dly #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [D];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < D; i++) sr_r[i] <= sr_r[i-1];
    end
  end

  assign q = sr_r[D-1];

endmodule

>>> rtl/ptp_mul.sv
// Three-stage signed multiplier built from four half-width partial products.
module ptp_mul #(
  parameter int W = 33
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);

  localparam int HW = (W + 1) / 2;
  localparam int LW = W - HW;

  logic [W-1:0]       ma_nxt, mb_nxt;
  logic [W-1:0]       ma_r, mb_r;
  logic               neg1_r, neg2_r;
  logic [2*HW-1:0]    pll_r;
  logic [HW+LW-1:0]   plh_r, phl_r;
  logic [2*LW-1:0]    phh_r;
  logic [2*W-1:0]     sum_nxt;
  logic signed [2*W-1:0] p_r;

  always_comb begin
    ma_nxt  = a[W-1] ? W'(-a) : W'(a);
    mb_nxt  = b[W-1] ? W'(-b) : W'(b);
    sum_nxt = {phh_r, {(2*HW){1'b0}}}
            + (((2*W)'(plh_r) + (2*W)'(phl_r)) << HW)
            + (2*W)'(pll_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r   <= ma_nxt;
      mb_r   <= mb_nxt;
      neg1_r <= a[W-1] ^ b[W-1];
      pll_r  <= ma_r[HW-1:0] * mb_r[HW-1:0];
      plh_r  <= ma_r[HW-1:0] * mb_r[W-1:HW];
      phl_r  <= ma_r[W-1:HW] * mb_r[HW-1:0];
      phh_r  <= ma_r[W-1:HW] * mb_r[W-1:HW];
      neg2_r <= neg1_r;
      p_r    <= neg2_r ? $signed(-sum_nxt) : $signed(sum_nxt);
    end
  end

  assign p = p_r;

endmodule

>>> rtl/ptp_div.sv
// Pipelined restoring divider: two numerators over one divisor, one quotient bit per stage.
module ptp_div #(
  parameter int DW = 18,
  parameter int QW = 17,
  parameter int SW = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [DW+QW-1:0]   num1,
  input  logic [DW+QW-1:0]   num2,
  input  logic [DW-1:0]      den,
  input  logic [SW-1:0]      side_in,
  output logic               out_vld,
  output logic [QW-1:0]      quo1,
  output logic [QW-1:0]      quo2,
  output logic [SW-1:0]      side_out
);

  logic [QW-1:0] vld_r;
  logic [DW-1:0] r1_r   [QW];
  logic [DW-1:0] r2_r   [QW];
  logic [QW-1:0] lo1_r  [QW];
  logic [QW-1:0] lo2_r  [QW];
  logic [QW-1:0] q1_r   [QW];
  logic [QW-1:0] q2_r   [QW];
  logic [DW-1:0] den_r  [QW];
  logic [SW-1:0] side_r [QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW-2:0], in_vld};
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] r1_p, r2_p, den_p;
    logic [QW-1:0] lo1_p, lo2_p, q1_p, q2_p;
    logic [SW-1:0] side_p;
    logic [DW:0]   t1, t2;
    logic          ge1, ge2;

    if (k == 0) begin : g_first
      assign r1_p   = num1[DW+QW-1:QW];
      assign r2_p   = num2[DW+QW-1:QW];
      assign lo1_p  = num1[QW-1:0];
      assign lo2_p  = num2[QW-1:0];
      assign q1_p   = '0;
      assign q2_p   = '0;
      assign den_p  = den;
      assign side_p = side_in;
    end else begin : g_next
      assign r1_p   = r1_r[k-1];
      assign r2_p   = r2_r[k-1];
      assign lo1_p  = lo1_r[k-1];
      assign lo2_p  = lo2_r[k-1];
      assign q1_p   = q1_r[k-1];
      assign q2_p   = q2_r[k-1];
      assign den_p  = den_r[k-1];
      assign side_p = side_r[k-1];
    end

    always_comb begin
      t1  = {r1_p, lo1_p[QW-1]};
      t2  = {r2_p, lo2_p[QW-1]};
      ge1 = t1 >= {1'b0, den_p};
      ge2 = t2 >= {1'b0, den_p};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r1_r[k]   <= ge1 ? DW'(t1 - {1'b0, den_p}) : t1[DW-1:0];
        r2_r[k]   <= ge2 ? DW'(t2 - {1'b0, den_p}) : t2[DW-1:0];
        q1_r[k]   <= {q1_p[QW-2:0], ge1};
        q2_r[k]   <= {q2_p[QW-2:0], ge2};
        lo1_r[k]  <= lo1_p << 1;
        lo2_r[k]  <= lo2_p << 1;
        den_r[k]  <= den_p;
        side_r[k] <= side_p;
      end
    end
  end

  assign out_vld  = vld_r[QW-1];
  assign quo1     = q1_r[QW-1];
  assign quo2     = q2_r[QW-1];
  assign side_out = side_r[QW-1];

endmodule

>>> rtl/ptp_gram.sv
// Edge vectors, Gram products and the 2x2 solve numerators with degenerate check.
module ptp_gram (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_vld,
  input  logic [ptp_pkg::NCRD-1:0][ptp_pkg::CRD_W-1:0] crd,
  input  logic [ptp_pkg::LIM_W-1:0]            limit,
  output logic                                 out_vld,
  output logic [ptp_pkg::GRM_W-1:0]            det,
  output logic [ptp_pkg::GRM_W-1:0]            n1,
  output logic [ptp_pkg::GRM_W-1:0]            n2,
  output ptp_pkg::gram_t                       side
);

  localparam int DIF_W = ptp_pkg::DIF_W;
  localparam int DOT_W = ptp_pkg::DOT_W;
  localparam int GRM_W = ptp_pkg::GRM_W;
  localparam int NST   = 10;

  logic [NST-1:0] vld_r;

  ptp_pkg::geo_t geo1_nxt, geo1_r, geo_m1, geo5_r, geo_m2, geo9_r;
  logic [2:0][DIF_W-1:0] q_nxt, q_r;

  logic signed [DIF_W-1:0]   ma [15];
  logic signed [DIF_W-1:0]   mb [15];
  logic signed [2*DIF_W-1:0] mp [15];
  logic signed [DOT_W-1:0]   dot_nxt [5];
  logic signed [DOT_W-1:0]   dot_r   [5];
  logic signed [DOT_W-1:0]   ga [6];
  logic signed [DOT_W-1:0]   gb [6];
  logic signed [GRM_W-1:0]   gp [6];
  logic signed [GRM_W-1:0]   det9_r, n19_r, n29_r;
  logic [GRM_W-1:0]          detm_nxt, n1f_nxt, n2f_nxt;
  logic [GRM_W-1:0]          det_r, n1_r, n2_r;
  ptp_pkg::gram_t            side_nxt, side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_vld};
    end
  end

  // corner C is the origin of the local frame
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      geo1_nxt.pc[i] = crd[6+i];
      geo1_nxt.e1[i] = DIF_W'($signed({crd[i][31], crd[i]}) - $signed({crd[6+i][31], crd[6+i]}));
      geo1_nxt.e2[i] = DIF_W'($signed({crd[3+i][31], crd[3+i]})
                              - $signed({crd[6+i][31], crd[6+i]}));
      q_nxt[i]       = DIF_W'($signed({crd[9+i][31], crd[9+i]})
                              - $signed({crd[6+i][31], crd[6+i]}));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo1_r <= geo1_nxt;
      q_r    <= q_nxt;
    end
  end

  // products for e1.e1, e1.e2, e2.e2, e1.q, e2.q
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ma[i]    = $signed(geo1_r.e1[i]);  mb[i]    = $signed(geo1_r.e1[i]);
      ma[3+i]  = $signed(geo1_r.e1[i]);  mb[3+i]  = $signed(geo1_r.e2[i]);
      ma[6+i]  = $signed(geo1_r.e2[i]);  mb[6+i]  = $signed(geo1_r.e2[i]);
      ma[9+i]  = $signed(geo1_r.e1[i]);  mb[9+i]  = $signed(q_r[i]);
      ma[12+i] = $signed(geo1_r.e2[i]);  mb[12+i] = $signed(q_r[i]);
    end
  end

  for (genvar k = 0; k < 15; k++) begin : g_mul1
    ptp_mul #(.W(DIF_W)) u_mul (.clk(clk), .en(en), .a(ma[k]), .b(mb[k]), .p(mp[k]));
  end

  ptp_dly #(.W($bits(ptp_pkg::geo_t)), .D(3)) u_dly1 (
    .clk(clk), .en(en), .d(geo1_r), .q(geo_m1)
  );

  always_comb begin
    for (int j = 0; j < 5; j++) begin
      dot_nxt[j] = DOT_W'(mp[3*j]) + DOT_W'(mp[3*j+1]) + DOT_W'(mp[3*j+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 5; j++) dot_r[j] <= dot_nxt[j];
      geo5_r <= geo_m1;
    end
  end

  // dot_r: a, b, c, d1, d2; pairs a*c, b*b, c*d1, b*d2, a*d2, b*d1
  always_comb begin
    ga[0] = dot_r[0]; gb[0] = dot_r[2];
    ga[1] = dot_r[1]; gb[1] = dot_r[1];
    ga[2] = dot_r[2]; gb[2] = dot_r[3];
    ga[3] = dot_r[1]; gb[3] = dot_r[4];
    ga[4] = dot_r[0]; gb[4] = dot_r[4];
    ga[5] = dot_r[1]; gb[5] = dot_r[3];
  end

  for (genvar k = 0; k < 6; k++) begin : g_mul2
    ptp_mul #(.W(DOT_W)) u_mul (.clk(clk), .en(en), .a(ga[k]), .b(gb[k]), .p(gp[k]));
  end

  ptp_dly #(.W($bits(ptp_pkg::geo_t)), .D(3)) u_dly2 (
    .clk(clk), .en(en), .d(geo5_r), .q(geo_m2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      det9_r <= gp[0] - gp[1];
      n19_r  <= gp[2] - gp[3];
      n29_r  <= gp[4] - gp[5];
      geo9_r <= geo_m2;
    end
  end

  // fold a negative determinant into its magnitude; take the clamp decisions
  always_comb begin
    detm_nxt = det9_r[GRM_W-1] ? GRM_W'(-det9_r) : GRM_W'(det9_r);
    n1f_nxt  = det9_r[GRM_W-1] ? GRM_W'(-n19_r)  : GRM_W'(n19_r);
    n2f_nxt  = det9_r[GRM_W-1] ? GRM_W'(-n29_r)  : GRM_W'(n29_r);
    side_nxt.geo    = geo9_r;
    side_nxt.deg    = (detm_nxt == '0) || (detm_nxt < GRM_W'(limit));
    side_nxt.n1_neg = n1f_nxt[GRM_W-1];
    side_nxt.n1_big = !n1f_nxt[GRM_W-1] && (n1f_nxt > detm_nxt);
    side_nxt.n2_neg = n2f_nxt[GRM_W-1];
    side_nxt.n2_big = !n2f_nxt[GRM_W-1] && (n2f_nxt > detm_nxt);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_r  <= detm_nxt;
      n1_r   <= n1f_nxt;
      n2_r   <= n2f_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_vld = vld_r[NST-1];
  assign det     = det_r;
  assign n1      = n1_r;
  assign n2      = n2_r;
  assign side    = side_r;

endmodule

>>> rtl/ptp_edge.sv
// Weight clamp, edge correction toward AB and the saturated projected point.
module ptp_edge (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [ptp_pkg::WT_W-1:0]   q1,
  input  logic [ptp_pkg::WT_W-1:0]   q2,
  input  ptp_pkg::gram_t             side,
  output logic                       out_vld,
  output ptp_pkg::res_t              res
);

  localparam int WT_W  = ptp_pkg::WT_W;
  localparam int WS_W  = ptp_pkg::WS_W;
  localparam int NUM_W = ptp_pkg::NUM_W;
  localparam int PRD_W = ptp_pkg::PRD_W;
  localparam int ACC_W = ptp_pkg::ACC_W;
  localparam int CRD_W = ptp_pkg::CRD_W;

  logic                e1_vld_r, e2_vld_r, e3_vld_r, e4_vld_r, e5_vld_r;
  ptp_pkg::edge_t      ed_nxt, ed1_r, ed2_r, ed_div;
  logic [WS_W-1:0]     s_nxt;
  logic [NUM_W-1:0]    num1_r, num2_r;
  logic                div_vld;
  logic [WT_W-1:0]     t1, t2;

  logic [WT_W-1:0]     wa_nxt, wb_nxt, wc_nxt;
  logic [WT_W-1:0]     wa_r, wb_r, wc_r, wa4_r, wb4_r, wc4_r;
  logic                ok_r, ok4_r, ins_r, ins4_r;
  ptp_pkg::geo_t       geo3_r;
  logic [2:0][CRD_W-1:0] pc4_r;
  logic signed [PRD_W-1:0] pa_r [3];
  logic signed [PRD_W-1:0] pb_r [3];
  logic signed [ACC_W-1:0] acc  [3];
  logic signed [ACC_W-1:0] sh   [3];
  ptp_pkg::res_t       res_nxt, res_r;

  always_comb begin
    ed_nxt.geo      = side.geo;
    ed_nxt.deg      = side.deg;
    ed_nxt.interior = !(side.n1_neg || side.n1_big || side.n2_neg || side.n2_big);
    ed_nxt.w1       = side.n1_neg ? '0 : (side.n1_big ? ptp_pkg::ONE_Q16 : q1);
    ed_nxt.w2       = side.n2_neg ? '0 : (side.n2_big ? ptp_pkg::ONE_Q16 : q2);
    ed_nxt.w12      = {1'b0, ed_nxt.w1} + {1'b0, ed_nxt.w2};
    ed_nxt.corr     = ed_nxt.w12 > {1'b0, ptp_pkg::ONE_Q16};
    s_nxt           = ed1_r.w12 - {1'b0, ptp_pkg::ONE_Q16};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_vld_r <= 1'b0;
      e2_vld_r <= 1'b0;
    end else if (en) begin
      e1_vld_r <= in_vld;
      e2_vld_r <= e1_vld_r;
    end
  end

  // numerators of the rounded share of the excess that each weight gives up
  always_ff @(posedge clk) begin
    if (en) begin
      ed1_r  <= ed_nxt;
      ed2_r  <= ed1_r;
      num1_r <= NUM_W'(ed1_r.w2) * NUM_W'(s_nxt) + NUM_W'(ed1_r.w12 >> 1);
      num2_r <= NUM_W'(ed1_r.w1) * NUM_W'(s_nxt) + NUM_W'(ed1_r.w12 >> 1);
    end
  end

  ptp_div #(.DW(WS_W), .QW(WT_W), .SW($bits(ptp_pkg::edge_t))) u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(e2_vld_r),
    .num1(num1_r), .num2(num2_r), .den(ed2_r.w12), .side_in(ed2_r),
    .out_vld(div_vld), .quo1(t1), .quo2(t2), .side_out(ed_div)
  );

  always_comb begin
    if (ed_div.corr) begin
      wa_nxt = (t1 > ed_div.w1) ? '0 : ed_div.w1 - t1;
      wb_nxt = (t2 > ed_div.w2) ? '0 : ed_div.w2 - t2;
      wc_nxt = '0;
    end else begin
      wa_nxt = ed_div.w1;
      wb_nxt = ed_div.w2;
      wc_nxt = ptp_pkg::ONE_Q16 - ed_div.w1 - ed_div.w2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e3_vld_r <= 1'b0;
      e4_vld_r <= 1'b0;
      e5_vld_r <= 1'b0;
    end else if (en) begin
      e3_vld_r <= div_vld;
      e4_vld_r <= e3_vld_r;
      e5_vld_r <= e4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wa_r   <= wa_nxt;
      wb_r   <= wb_nxt;
      wc_r   <= wc_nxt;
      ok_r   <= !ed_div.deg;
      ins_r  <= ed_div.interior && !ed_div.corr;
      geo3_r <= ed_div.geo;
      for (int i = 0; i < 3; i++) begin
        pa_r[i] <= $signed({1'b0, wa_r}) * $signed(geo3_r.e1[i]);
        pb_r[i] <= $signed({1'b0, wb_r}) * $signed(geo3_r.e2[i]);
      end
      pc4_r  <= geo3_r.pc;
      wa4_r  <= wa_r;
      wb4_r  <= wb_r;
      wc4_r  <= wc_r;
      ok4_r  <= ok_r;
      ins4_r <= ins_r;
      res_r  <= res_nxt;
    end
  end

  // round half up, floor to Q16.16, saturate; a degenerate triangle gives all zeros
  always_comb begin
    res_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      acc[i] = (ACC_W'($signed(pc4_r[i])) <<< 16) + ACC_W'(pa_r[i]) + ACC_W'(pb_r[i])
             + ptp_pkg::HALF_LSB;
      sh[i]  = acc[i] >>> 16;
      if (&sh[i][ACC_W-1:CRD_W-1] || ~|sh[i][ACC_W-1:CRD_W-1]) begin
        res_nxt.proj[i] = sh[i][CRD_W-1:0];
      end else begin
        res_nxt.proj[i] = {sh[i][ACC_W-1], {(CRD_W-1){~sh[i][ACC_W-1]}}};
      end
    end
    res_nxt.valid_res  = ok4_r;
    res_nxt.inside_res = ins4_r;
    res_nxt.wa         = wa4_r;
    res_nxt.wb         = wb4_r;
    res_nxt.wc         = wc4_r;
    if (!ok4_r) res_nxt = '0;
  end

  assign out_vld = e5_vld_r;
  assign res     = res_r;

endmodule
